>>> hdl/ntfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfi_pkg
// Shared types and constants for the name table find-or-insert unit.
// ----------------------------------------------------------------------------
package ntfi_pkg;

    localparam int TABLE_SLOTS_DEF = 2048;
    localparam int NAME_BYTES_DEF  = 8;

    localparam int KEY_W       = 64;
    localparam int SLOT_INDEX_W = 11;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic probe_step;
        logic clear_step;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic hash_done;
        logic probe_done;
    } t_sts;

endpackage
`default_nettype wire

>>> hdl/name_table_find_or_insert_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// name_table_find_or_insert_unit
// Open-addressing symbol table with linear probing: finds or inserts a name.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one packed name word;
// output channel (o_out_valid / i_out_ready) returns slot index and status
// (found, inserted, table full), one result word per name word.
// One name is processed at a time: its bytes are hashed, with extra fold
// steps to bring the hash below the table size, the first slot is read, the
// probe walk follows and the result is handed off. Tables under 256 slots
// may need more fold steps per byte than larger ones. The probe walk is set
// by the single read port of the slot memory: one slot per cycle.
// The next name is taken in the cycle after the hand-off.
// After reset the unit sweeps the slot memory to mark every slot empty,
// with o_in_ready low.
// The finished result sits in an output register; the next name is taken
// while it waits. If the receiver stalls, a second result is held inside
// and no further name is accepted until the output word is taken.
// ----------------------------------------------------------------------------
module name_table_find_or_insert_unit #(
    parameter int TABLE_SLOTS = ntfi_pkg::TABLE_SLOTS_DEF,
    parameter int NAME_BYTES  = ntfi_pkg::NAME_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ntfi_pkg::KEY_W-1:0]    i_name_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ntfi_pkg::SLOT_INDEX_W-1:0]  o_slot_index,
    output logic [ntfi_pkg::STATUS_W-1:0]      o_status
);
    import ntfi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ntfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ntfi_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_name_key   (i_name_key),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_slot_index (o_slot_index),
        .o_status     (o_status)
    );

endmodule
`default_nettype wire

>>> hdl/ntfi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfi_ctrl
// Sequencer: clearing pass, hash walk, probe walk and output hand-off.
// ----------------------------------------------------------------------------
module ntfi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ntfi_pkg::t_sts i_sts,
    output ntfi_pkg::t_cmd     o_cmd
);
    import ntfi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.probe_step = 1'b1;
                if (i_sts.probe_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output word is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> hdl/ntfi_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfi_dp
// Key canonicalization, byte-serial hash, slot memory and probe compare.
// ----------------------------------------------------------------------------
module ntfi_dp #(
    parameter int TABLE_SLOTS = ntfi_pkg::TABLE_SLOTS_DEF,
    parameter int NAME_BYTES  = ntfi_pkg::NAME_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ntfi_pkg::KEY_W-1:0]    i_name_key,
    input  wire ntfi_pkg::t_cmd                i_cmd,
    output ntfi_pkg::t_sts                     o_sts,
    output logic [ntfi_pkg::SLOT_INDEX_W-1:0]  o_slot_index,
    output logic [ntfi_pkg::STATUS_W-1:0]      o_status
);
    import ntfi_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int BASE_W = (IDX_W > 8) ? IDX_W : 8;
    localparam int V_W    = BASE_W + 2;
    localparam int BI_W   = $clog2(NAME_BYTES + 1);

    localparam logic [V_W-1:0]   T_V    = V_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] Q_LAST = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [BI_W-1:0]  BI_END = BI_W'(NAME_BYTES);

    // slot word: occupied flag on top of the key
    logic [KEY_W:0] r_mem [TABLE_SLOTS];
    logic [KEY_W:0] r_rd;
    logic [IDX_W-1:0] rd_addr;

    logic [KEY_W-1:0] canon;
    logic             alive;
    logic [KEY_W-1:0] r_key;
    logic [V_W-1:0]   r_v, n_v;
    logic [BI_W-1:0]  r_bidx, n_bidx;
    logic [IDX_W-1:0] r_q, n_q;
    logic [IDX_W-1:0] r_start, n_start;
    logic [IDX_W-1:0] q_next;

    logic [3:0]       bidx4;
    logic [7:0]       byte_cur;
    logic             hash_end;
    logic [V_W-1:0]   h2;

    logic             occ;
    logic             key_eq;

    logic [IDX_W-1:0]        r_res_q;
    logic [STATUS_W-1:0]     r_res_st;
    logic [SLOT_INDEX_W-1:0] r_out_slot;
    logic [STATUS_W-1:0]     r_out_st;
    logic [31:0]             res_ext;

    // clear everything after the first zero byte and beyond the name length
    always_comb begin
        canon = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i >= NAME_BYTES || i_name_key[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                canon[8*i +: 8] = i_name_key[8*i +: 8];
            end
        end
    end

    assign bidx4    = 4'(r_bidx);
    assign byte_cur = r_key[8*bidx4[2:0] +: 8];
    assign hash_end = (r_bidx == BI_END) || (byte_cur == 8'd0);
    assign h2       = {r_v[V_W-2:0], 1'b0} + V_W'(byte_cur);

    always_comb begin
        n_v    = r_v;
        n_bidx = r_bidx;
        if (i_cmd.load) begin
            n_v    = '0;
            n_bidx = '0;
        end else if (i_cmd.hash_step) begin
            if (r_v >= T_V) begin
                n_v = r_v - T_V;
            end else if (!hash_end) begin
                // fold: 2h + byte, plus 1 minus T on overflow; first subtraction done here
                n_v    = (h2 >= T_V) ? (h2 + V_W'(1) - T_V) : h2;
                n_bidx = r_bidx + BI_W'(1);
            end
        end
    end

    assign occ    = r_rd[KEY_W];
    assign key_eq = (r_rd[KEY_W-1:0] == r_key);
    assign q_next = (r_q == Q_LAST) ? '0 : r_q + IDX_W'(1);

    always_comb begin
        o_sts.hash_done  = (r_v < T_V) && hash_end;
        o_sts.probe_done = !occ || key_eq || (q_next == r_start);
        o_sts.clear_last = (r_q == Q_LAST);
    end

    always_comb begin
        n_q     = r_q;
        n_start = r_start;
        if (i_cmd.clear_step) begin
            n_q = q_next;
        end else if (i_cmd.hash_step && o_sts.hash_done) begin
            n_q     = r_v[IDX_W-1:0];
            n_start = r_v[IDX_W-1:0];
        end else if (i_cmd.probe_step && !o_sts.probe_done) begin
            n_q = q_next;
        end
    end

    assign rd_addr = i_cmd.hash_step ? r_v[IDX_W-1:0] : q_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_bidx  <= n_bidx;
        r_start <= n_start;
        if (i_cmd.load) begin
            r_key <= canon;
        end
        if (i_cmd.probe_step && o_sts.probe_done) begin
            priority if (!occ) begin
                r_res_q  <= r_q;
                r_res_st <= ST_INSERTED;
            end else if (key_eq) begin
                r_res_q  <= r_q;
                r_res_st <= ST_FOUND;
            end else begin
                r_res_q  <= '0;
                r_res_st <= ST_FULL;
            end
        end
        if (i_cmd.out_load) begin
            r_out_slot <= res_ext[SLOT_INDEX_W-1:0];
            r_out_st   <= r_res_st;
        end
    end

    assign res_ext = 32'(r_res_q);

    // slot memory: at most one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_q] <= '0;
        end else if (i_cmd.probe_step && !occ) begin
            r_mem[r_q] <= {1'b1, r_key};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_slot_index = r_out_slot;
    assign o_status     = r_out_st;

endmodule
`default_nettype wire
